// ===== sv/hpl_pkg.sv =====
// Shared constants, CORDIC angle table and unit request/response types
// for the haversine path length block. No dependencies.
package hpl_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int TABLE_LEN = 40;
  localparam int LAT_W = 31;
  localparam int LON_W = 32;
  localparam int SEG_W = 35;
  localparam int TOT_W = 48;
  localparam int RAD_W = 23;
  localparam int CW = 34;  // CORDIC datapath width
  localparam int NW = 38;  // scaled coordinate width before divide

  localparam logic [RAD_W-1:0] RADIUS_DEF = 23'd6371000;
  localparam logic signed [CW-1:0] GAIN_SEED = 34'sd652032874;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [33:0] PI_Q32 = 34'd13493037705;
  localparam logic [TOT_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic                 start;
    logic                 vector_mode;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_rsp_t;

  // atan(2^-i) in binary angle units, 2^32 per turn
  function automatic logic [31:0] angle_step(input logic [5:0] i);
    logic [31:0] v;
    unique case (i)
      6'd0:  v = 32'd536870912;
      6'd1:  v = 32'd316933406;
      6'd2:  v = 32'd167458907;
      6'd3:  v = 32'd85004756;
      6'd4:  v = 32'd42667331;
      6'd5:  v = 32'd21354465;
      6'd6:  v = 32'd10679838;
      6'd7:  v = 32'd5340245;
      6'd8:  v = 32'd2670163;
      6'd9:  v = 32'd1335087;
      6'd10: v = 32'd667544;
      6'd11: v = 32'd333772;
      6'd12: v = 32'd166886;
      6'd13: v = 32'd83443;
      6'd14: v = 32'd41722;
      6'd15: v = 32'd20861;
      6'd16: v = 32'd10430;
      6'd17: v = 32'd5215;
      6'd18: v = 32'd2608;
      6'd19: v = 32'd1304;
      6'd20: v = 32'd652;
      6'd21: v = 32'd326;
      6'd22: v = 32'd163;
      6'd23: v = 32'd81;
      6'd24: v = 32'd41;
      6'd25: v = 32'd20;
      6'd26: v = 32'd10;
      6'd27: v = 32'd5;
      6'd28: v = 32'd3;
      6'd29: v = 32'd1;
      6'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/hpl_if.sv =====
// Handshake channel interfaces: waypoint input, result output, radius write.
// Depends on hpl_pkg for field widths.
interface hpl_point_if;
  import hpl_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] latitude;
  logic signed [LON_W-1:0] longitude;
  logic                    last_point;
  modport source(output valid, latitude, longitude, last_point, input ready);
  modport sink(input valid, latitude, longitude, last_point, output ready);
endinterface

interface hpl_result_if;
  import hpl_pkg::*;
  logic             valid;
  logic             ready;
  logic [SEG_W-1:0] segment_mm;
  logic [TOT_W-1:0] total_mm;
  logic             path_done;
  modport source(output valid, segment_mm, total_mm, path_done, input ready);
  modport sink(input valid, segment_mm, total_mm, path_done, output ready);
endinterface

interface hpl_cfg_if;
  import hpl_pkg::*;
  logic             valid;
  logic             ready;
  logic [RAD_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== sv/hpl_div90.sv =====
// Divide by 90 with rounding by reciprocal multiplication: turns a scaled
// coordinate into a binary angle, round(n / 45) ties away from zero.
// Depends on hpl_pkg.
module hpl_div90 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [hpl_pkg::NW-1:0] n,
  output logic                          done,
  output logic [31:0]                   bam
);
  import hpl_pkg::*;

  localparam int DW  = NW + 1;
  localparam int HW  = 20;           // half width of the reciprocal
  localparam int PW  = DW + HW;      // partial product width
  localparam int AW  = DW + 2 * HW;  // full product width
  localparam int RSH = 46;
  // ceil(2^46 / 90): exact floor quotient for any dividend below 2^39
  localparam logic [2*HW-1:0] RECIP = 40'd781874935308;

  logic [DW-1:0] dvd;
  logic [AW-1:0] acc;
  logic [HW-1:0] rpart;
  logic [PW-1:0] pp;
  logic [31:0]   quo;
  logic          busy;
  logic          hi;
  logic          neg;
  logic [NW-1:0] mag;

  assign mag   = n[NW-1] ? NW'(-n) : NW'(n);
  assign rpart = hi ? RECIP[2*HW-1:HW] : RECIP[HW-1:0];
  assign pp    = PW'(dvd) * PW'(rpart);
  assign quo   = acc[RSH+31:RSH];
  assign bam   = neg ? -quo : quo;

  // low half of the reciprocal first, then add the high half shifted up
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      hi   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        hi   <= 1'b0;
        dvd  <= {mag, 1'b0} + DW'(45);
        neg  <= n[NW-1];
      end else if (busy) begin
        if (!hi) begin
          acc <= AW'(pp);
          hi  <= 1'b1;
        end else begin
          acc  <= acc + {pp, {HW{1'b0}}};
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/hpl_sqrt.sv =====
// Shift-subtract integer square root, one result bit per cycle,
// 32 iterations. No package dependencies.
module hpl_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] v_in,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] v;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] trial;
  logic        ge;

  assign trial = r + bitv;
  assign ge    = v >= trial;
  assign root  = r[31:0];

  // one recurrence step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        v    <= v_in;
        r    <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if (ge) begin
          v <= v - trial;
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 1'b1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/hpl_cordic.sv =====
// Iterative CORDIC, rotation mode (sine/cosine) or vectoring mode (atan2),
// one micro-rotation per cycle. Depends on hpl_pkg for the angle table.
module hpl_cordic #(
  parameter int CORDIC_STEPS = hpl_pkg::CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hpl_pkg::cordic_req_t req,
  output hpl_pkg::cordic_rsp_t rsp
);
  import hpl_pkg::*;

  localparam int NSTEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [CW-1:0] z;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] st;
  logic [5:0]           cnt;
  logic                 busy;
  logic                 vec;
  logic                 sub;
  logic                 done;

  assign dx  = y >>> cnt;
  assign dy  = x >>> cnt;
  assign st  = signed'(CW'(angle_step(cnt)));
  assign sub = vec ? y[CW-1] : ~z[CW-1];

  assign rsp.done = done;
  assign rsp.x    = x;
  assign rsp.y    = y;
  assign rsp.z    = z;

  // rotate toward the target, one step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        vec  <= req.vector_mode;
        x    <= req.x;
        y    <= req.y;
        z    <= req.z;
      end else if (busy) begin
        x   <= sub ? x - dx : x + dx;
        y   <= sub ? y + dy : y - dy;
        z   <= sub ? z - st : z + st;
        cnt <= cnt + 1'b1;
        if (cnt == 6'(NSTEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/hpl_seq.sv =====
// Sequencer for one segment: angle conversion, four sin/cos runs, products,
// two square roots, atan2 and final scaling. Uses hpl_div90, hpl_cordic,
// hpl_sqrt and hpl_pkg.
module hpl_seq #(
  parameter int CORDIC_STEPS = hpl_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [hpl_pkg::LAT_W-1:0] la1,
  input  logic signed [hpl_pkg::LON_W-1:0] lo1,
  input  logic signed [hpl_pkg::LAT_W-1:0] la2,
  input  logic signed [hpl_pkg::LON_W-1:0] lo2,
  input  logic [hpl_pkg::RAD_W-1:0]       radius,
  output logic                          done,
  output logic [hpl_pkg::SEG_W-1:0]       seg
);
  import hpl_pkg::*;

  localparam int AW = 98;
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DIV_GO  = 4'd1;
  localparam logic [3:0] S_DIV_WT  = 4'd2;
  localparam logic [3:0] S_SC_GO   = 4'd3;
  localparam logic [3:0] S_SC_WT   = 4'd4;
  localparam logic [3:0] S_MUL_A   = 4'd5;
  localparam logic [3:0] S_MUL_B   = 4'd6;
  localparam logic [3:0] S_SUM     = 4'd7;
  localparam logic [3:0] S_SQ_GO   = 4'd8;
  localparam logic [3:0] S_SQ_WT   = 4'd9;
  localparam logic [3:0] S_AT_GO   = 4'd10;
  localparam logic [3:0] S_AT_WT   = 4'd11;
  localparam logic [3:0] S_PI      = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;
  localparam logic signed [CW:0]   ONE_W = (CW+1)'(ONE_Q30);
  localparam logic signed [CW-1:0] ONE_C = CW'(ONE_Q30);

  logic [3:0]             state;
  logic [1:0]             k;
  logic [2:0]             m;
  logic [5:0]             pidx;
  logic [31:0]            bam [4];
  logic signed [CW-1:0]   sc [4];
  logic                   flip;
  logic signed [CW-1:0]   t1, cc, ss, t2;
  logic [30:0]            a_q;
  logic [31:0]            sa, sb;
  logic [30:0]            zc;
  logic [63:0]            q;
  logic signed [2*CW-1:0] prod;
  logic [AW-1:0]          acc;

  logic signed [NW-1:0]   div_n;
  logic                   div_done;
  logic [31:0]            div_bam;
  logic [31:0]            rot_t;
  logic                   rot_flip;
  logic [31:0]            rot_a;
  logic [63:0]            sq_in;
  logic                   sq_start;
  logic                   sq_done;
  logic [31:0]            sq_root;
  cordic_req_t            creq;
  cordic_rsp_t            crsp;
  logic signed [CW-1:0]   opa, opb;
  logic signed [CW:0]     asum;
  logic [32:0]            r1000;
  logic [AW-62-1:0]       seg_full;

  // scaled coordinate for each conversion
  always_comb begin
    case (k)
      2'd0:    div_n = NW'(la1) <<< 6;
      2'd1:    div_n = NW'(la2) <<< 6;
      2'd2:    div_n = (NW'(la2) - NW'(la1)) <<< 5;
      default: div_n = (NW'(lo2) - NW'(lo1)) <<< 5;
    endcase
  end

  hpl_div90 u_div (
    .clk(clk), .rst(rst), .start(state == S_DIV_GO), .n(div_n),
    .done(div_done), .bam(div_bam)
  );

  // fold the angle into the right half plane
  assign rot_t    = bam[k];
  assign rot_a    = rot_t + 32'h4000_0000;
  assign rot_flip = rot_a[31];

  always_comb begin
    creq.start       = (state == S_SC_GO) || (state == S_AT_GO);
    creq.vector_mode = (state == S_AT_GO);
    if (state == S_AT_GO) begin
      creq.x = signed'({2'b00, sb});
      creq.y = signed'({2'b00, sa});
      creq.z = '0;
    end else begin
      creq.x = GAIN_SEED;
      creq.y = '0;
      creq.z = CW'(signed'(rot_flip ? rot_t + 32'h8000_0000 : rot_t));
    end
  end

  hpl_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .req(creq), .rsp(crsp)
  );

  assign sq_start = (state == S_SQ_GO);
  assign sq_in    = (k == 2'd0) ? {3'b000, a_q, 30'd0}
                                : {3'b000, ONE_Q30 - a_q, 30'd0};

  hpl_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .v_in(sq_in),
    .done(sq_done), .root(sq_root)
  );

  // shared multiplier operands
  assign r1000 = 33'(radius) * 33'd1000;
  always_comb begin
    case (m)
      3'd0: begin opa = sc[2]; opb = sc[2]; end
      3'd1: begin opa = sc[0]; opb = sc[1]; end
      3'd2: begin opa = sc[3]; opb = sc[3]; end
      3'd3: begin opa = cc;    opb = ss;    end
      default: begin
        opa = signed'({1'b0, r1000});
        opb = signed'({3'b000, zc});
      end
    endcase
  end

  assign asum     = {t1[CW-1], t1} + {t2[CW-1], t2};
  assign seg_full = acc[AW-1:62] + (AW-62)'(acc[61]);
  assign seg      = SEG_W'(seg_full);
  assign done     = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      m     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            k     <= '0;
            state <= S_DIV_GO;
          end
        end
        S_DIV_GO: state <= S_DIV_WT;
        // collect binary angles
        S_DIV_WT: begin
          if (div_done) begin
            bam[k] <= div_bam;
            k      <= k + 1'b1;
            state  <= (k == 2'd3) ? S_SC_GO : S_DIV_GO;
          end
        end
        S_SC_GO: begin
          flip  <= rot_flip;
          state <= S_SC_WT;
        end
        // keep cosines of the latitudes, sines of the half differences
        S_SC_WT: begin
          if (crsp.done) begin
            if (k[1] == 1'b0) begin
              sc[k] <= flip ? -crsp.x : crsp.x;
            end else begin
              sc[k] <= flip ? -crsp.y : crsp.y;
            end
            k <= k + 1'b1;
            if (k == 2'd3) begin
              m     <= '0;
              state <= S_MUL_A;
            end else begin
              state <= S_SC_GO;
            end
          end
        end
        S_MUL_A: begin
          prod  <= opa * opb;
          state <= S_MUL_B;
        end
        // store the first four products truncated back to Q30, keep the last one whole
        S_MUL_B: begin
          case (m)
            3'd0:    t1 <= prod[CW+29:30];
            3'd1:    cc <= prod[CW+29:30];
            3'd2:    ss <= prod[CW+29:30];
            3'd3:    t2 <= prod[CW+29:30];
            default: q  <= prod[63:0];
          endcase
          if (m == 3'd3) begin
            state <= S_SUM;
          end else if (m == 3'd4) begin
            acc   <= '0;
            pidx  <= 6'd33;
            state <= S_PI;
          end else begin
            m     <= m + 1'b1;
            state <= S_MUL_A;
          end
        end
        // clamp the haversine term to [0, 1.0]
        S_SUM: begin
          if (asum[CW]) begin
            a_q <= '0;
          end else if (asum > ONE_W) begin
            a_q <= ONE_Q30;
          end else begin
            a_q <= asum[30:0];
          end
          k     <= '0;
          state <= S_SQ_GO;
        end
        S_SQ_GO: state <= S_SQ_WT;
        S_SQ_WT: begin
          if (sq_done) begin
            if (k == 2'd0) begin
              sa    <= sq_root;
              k     <= 2'd1;
              state <= S_SQ_GO;
            end else begin
              sb    <= sq_root;
              state <= S_AT_GO;
            end
          end
        end
        S_AT_GO: state <= S_AT_WT;
        // clamp half the central angle to [0, quarter turn]
        S_AT_WT: begin
          if (crsp.done) begin
            if (crsp.z[CW-1]) begin
              zc <= '0;
            end else if (crsp.z > ONE_C) begin
              zc <= ONE_Q30;
            end else begin
              zc <= crsp.z[30:0];
            end
            m     <= 3'd4;
            state <= S_MUL_A;
          end
        end
        // multiply by pi, one constant bit per cycle
        S_PI: begin
          acc  <= (acc << 1) + (PI_Q32[pidx] ? AW'(q) : AW'(0));
          pidx <= pidx - 1'b1;
          if (pidx == 6'd0) begin
            state <= S_DONE;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/haversine_path_length.sv =====
// Haversine path length: waypoint stream in, segment and running total out.
// Uses hpl_pkg, the hpl_if interfaces and hpl_seq.
//
// Channels: point (sink) carries latitude, longitude and last_point; result
// (source) carries segment_mm, total_mm and path_done; cfg (sink) writes the
// sphere radius in metres and is always ready. Every point yields one word.
// The first point of a path gives a zero segment without the sequencer.
// Any later point runs through the segment sequencer: four angle
// conversions by reciprocal multiply, four sin/cos CORDIC runs and one
// atan2 run, five products, the clamp, two 32-step square roots, a serial
// multiply by pi and the hand-off. Throughput is set by the one CORDIC
// unit, the square roots and the serial pi multiply, one point at a time.
// point.ready is high only while no point is in work. The result sits in an
// output register, so a stalled receiver holds the word while the next point
// may already be taken; that point's word then waits for the register.
// Reset clears the path state and the output, and loads the default radius.
// After a word with path_done set, the path state returns to zero.
module haversine_path_length #(
  parameter int CORDIC_STEPS = hpl_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  hpl_point_if.sink   point,
  hpl_result_if.source result,
  hpl_cfg_if.sink     cfg
);
  import hpl_pkg::*;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_RUN  = 2'd1;
  localparam logic [1:0] T_HOLD = 2'd2;

  logic [1:0]             state;
  logic [RAD_W-1:0]       radius;
  logic signed [LAT_W-1:0] prev_lat;
  logic signed [LON_W-1:0] prev_lon;
  logic                   have_prev;
  logic [TOT_W-1:0]       running_total;
  logic signed [LAT_W-1:0] cur_lat;
  logic signed [LON_W-1:0] cur_lon;
  logic                   cur_last;
  logic [SEG_W-1:0]       seg_hold;
  logic                   out_valid;
  logic [SEG_W-1:0]       out_seg;
  logic [TOT_W-1:0]       out_total;
  logic                   out_done;

  logic                   accept;
  logic                   seq_start;
  logic                   seq_done;
  logic [SEG_W-1:0]       seq_seg;
  logic                   load;
  logic [TOT_W:0]         sum;
  logic [TOT_W-1:0]       total_sat;

  assign point.ready      = (state == T_IDLE);
  assign cfg.ready        = 1'b1;
  assign result.valid     = out_valid;
  assign result.segment_mm = out_seg;
  assign result.total_mm  = out_total;
  assign result.path_done = out_done;

  assign accept    = point.valid && point.ready;
  assign seq_start = accept && have_prev;
  assign load      = (state == T_HOLD) && (!out_valid || result.ready);
  assign sum       = (TOT_W+1)'(running_total) + (TOT_W+1)'(seg_hold);
  assign total_sat = sum[TOT_W] ? TOTAL_MAX : sum[TOT_W-1:0];

  hpl_seq #(.CORDIC_STEPS(CORDIC_STEPS)) u_seq (
    .clk(clk), .rst(rst), .start(seq_start),
    .la1(prev_lat), .lo1(prev_lon), .la2(cur_lat), .lo2(cur_lon),
    .radius(radius), .done(seq_done), .seg(seq_seg)
  );

  // radius register
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_DEF;
    end else if (cfg.valid && cfg.ready) begin
      radius <= cfg.data;
    end
  end

  // take a point, run the segment, hand the word to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      out_valid     <= 1'b0;
      have_prev     <= 1'b0;
      running_total <= '0;
      prev_lat      <= '0;
      prev_lon      <= '0;
    end else begin
      if (out_valid && result.ready && !load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            cur_lat  <= point.latitude;
            cur_lon  <= point.longitude;
            cur_last <= point.last_point;
            seg_hold <= '0;
            state    <= have_prev ? T_RUN : T_HOLD;
          end
        end
        T_RUN: begin
          if (seq_done) begin
            seg_hold <= seq_seg;
            state    <= T_HOLD;
          end
        end
        T_HOLD: begin
          if (load) begin
            out_valid <= 1'b1;
            out_seg   <= seg_hold;
            out_total <= total_sat;
            out_done  <= cur_last;
            if (cur_last) begin
              prev_lat      <= '0;
              prev_lon      <= '0;
              have_prev     <= 1'b0;
              running_total <= '0;
            end else begin
              prev_lat      <= cur_lat;
              prev_lon      <= cur_lon;
              have_prev     <= 1'b1;
              running_total <= total_sat;
            end
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule
